// File: rtl/core/rgbm_pkg.sv
// Package for the RGB matrix scan and PWM driver: panel geometry, derived
// widths and the per-channel PWM compare. Depends on nothing.
package rgbm_pkg;

  localparam int ROWS = 16;
  localparam int COLS = 32;
  localparam int PAIR = 8;
  localparam int RES  = 16;

  localparam int STORE_DEPTH = ROWS * COLS;
  localparam int CYCLE_WRAP  = (256 / RES) * PAIR;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int COL_W       = $clog2(COLS);
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int PAIR_W      = $clog2(PAIR);
  localparam int CYCLE_W     = $clog2(CYCLE_WRAP);
  localparam int LEVEL_W     = CYCLE_W - PAIR_W;
  localparam int THR_W       = 9;
  localparam int PIX_W       = 24;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // floor(c / (RES-1)) > level holds exactly when c >= (level+1)*(RES-1),
  // so the threshold is formed once per tick and each channel is a compare.
  function automatic logic chan_on(input logic [7:0] c, input logic [THR_W-1:0] thr);
    return ({{(THR_W-8){1'b0}}, c} >= thr);
  endfunction

endpackage

// File: rtl/core/rgb_matrix_scan_pwm_driver.sv
// Top level of the RGB matrix scan and PWM driver: frame store memory,
// scan sequencer and output register. Depends on rgbm_pkg.
module rgb_matrix_scan_pwm_driver
  import rgbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       kind,
  input  logic [3:0] pixel_row,
  input  logic [4:0] pixel_col,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       result_strobe,
  output logic [2:0] row_address,
  output logic [4:0] column,
  output logic       upper_red,
  output logic       upper_green,
  output logic       upper_blue,
  output logic       lower_red,
  output logic       lower_green,
  output logic       lower_blue,
  output logic       last_column
);

  // After reset the block is busy while it clears all 512 entries of the
  // frame store to black, one entry per cycle. During a pixel write item busy
  // stays low, so writes can follow every cycle. A refresh tick item holds
  // busy high while the sequencer walks the columns, because it reads the
  // upper and lower pixel of one column per cycle from the store's two read
  // ports; the next item is taken in the cycle after the last column is read.
  // Results come one per cycle on result_strobe, the first after the tick has
  // passed the state register, s1_valid and result_strobe. The receiver cannot
  // stall them; result_strobe marks each result for exactly one cycle.

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN} state_t;

  state_t             state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [COL_W-1:0]   scan_col;
  logic [PAIR_W-1:0]  scan_pair;
  logic [CYCLE_W-1:0] pwm_cycle;
  logic [PAIR_W-1:0]  cur_pair;
  logic [THR_W-1:0]   thr;
  logic               upper_ok;
  logic               lower_ok;

  logic               s1_valid;
  logic [COL_W-1:0]   s1_col;

  logic [PIX_W-1:0]   mem [STORE_DEPTH];
  logic [PIX_W-1:0]   rd_up;
  logic [PIX_W-1:0]   rd_lo;

  logic               accept;
  logic               pix_we;
  logic               mem_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [PIX_W-1:0]   wr_data;
  logic [ROW_W-1:0]   flip_row;
  logic [ROW_W-1:0]   lo_row;
  logic [ADDR_W-1:0]  rd_addr_up;
  logic [ADDR_W-1:0]  rd_addr_lo;
  logic [LEVEL_W-1:0] level;
  logic [PIX_W-1:0]   pix_up;
  logic [PIX_W-1:0]   pix_lo;

  assign accept   = start && !busy;
  assign flip_row = ROW_W'(ROWS - 1) - ROW_W'(pixel_row);
  assign pix_we   = accept && (kind == KIND_WRITE) &&
                    (32'(pixel_row) < ROWS) && (32'(pixel_col) < COLS);

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      mem_we  = pix_we;
      wr_addr = {flip_row, COL_W'(pixel_col)};
      wr_data = {red, green, blue};
    end
  end

  assign lo_row     = ROW_W'(32'(cur_pair) + PAIR);
  assign rd_addr_up = {ROW_W'(cur_pair), scan_col};
  assign rd_addr_lo = {lo_row, scan_col};
  assign level      = LEVEL_W'(pwm_cycle / PAIR);

  // Rows outside the panel read as black.
  assign pix_up = upper_ok ? rd_up : '0;
  assign pix_lo = lower_ok ? rd_lo : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_up <= mem[rd_addr_up];
    rd_lo <= mem[rd_addr_lo];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      busy          <= 1'b1;
      clr_addr      <= '0;
      scan_col      <= '0;
      scan_pair     <= '0;
      pwm_cycle     <= '0;
      s1_valid      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      s1_valid      <= (state == ST_SCAN);
      s1_col        <= scan_col;
      result_strobe <= s1_valid;

      if (s1_valid) begin
        row_address <= 3'(cur_pair) + 3'd7;
        column      <= s1_col;
        upper_red   <= chan_on(pix_up[23:16], thr);
        upper_green <= chan_on(pix_up[15:8], thr);
        upper_blue  <= chan_on(pix_up[7:0], thr);
        lower_red   <= chan_on(pix_lo[23:16], thr);
        lower_green <= chan_on(pix_lo[15:8], thr);
        lower_blue  <= chan_on(pix_lo[7:0], thr);
        last_column <= (32'(s1_col) == COLS - 1);
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (32'(clr_addr) == STORE_DEPTH - 1) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (accept && (kind == KIND_TICK)) begin
            state    <= ST_SCAN;
            busy     <= 1'b1;
            scan_col <= '0;
            cur_pair <= scan_pair;
            upper_ok <= (32'(scan_pair) < ROWS);
            lower_ok <= (32'(scan_pair) + PAIR < ROWS);
            thr      <= THR_W'((THR_W'(level) + THR_W'(1)) * THR_W'(RES - 1));
            if (32'(scan_pair) == PAIR - 1) begin
              scan_pair <= '0;
            end else begin
              scan_pair <= scan_pair + PAIR_W'(1);
            end
            if (32'(pwm_cycle) == CYCLE_WRAP - 1) begin
              pwm_cycle <= '0;
            end else begin
              pwm_cycle <= pwm_cycle + CYCLE_W'(1);
            end
          end
        end
        ST_SCAN: begin
          scan_col <= scan_col + COL_W'(1);
          if (32'(scan_col) == COLS - 1) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
